// ----- hdl/pia_pkg.sv -----
// shared types, codes and helper functions of the parallel interface adapter
package pia_pkg;

  // item kinds on the input channel
  typedef enum logic [2:0] {
    ACC_READ   = 3'd0,
    ACC_WRITE  = 3'd1,
    ACC_CA1    = 3'd2,
    ACC_CA2    = 3'd3,
    ACC_CB1    = 3'd4,
    ACC_CB2    = 3'd5,
    ACC_PINS_A = 3'd6,
    ACC_PINS_B = 3'd7
  } access_e;

  // register offsets after the optional swap
  typedef enum logic [1:0] {
    REG_PORT_A = 2'd0,
    REG_CTRL_A = 2'd1,
    REG_PORT_B = 2'd2,
    REG_CTRL_B = 2'd3
  } reg_sel_e;

  // control register bit positions
  localparam int unsigned CrC1Irq   = 0;
  localparam int unsigned CrC1Edge  = 1;
  localparam int unsigned CrPortSel = 2;
  localparam int unsigned CrC2Bit3  = 3;
  localparam int unsigned CrC2Bit4  = 4;
  localparam int unsigned CrC2Out   = 5;

  localparam int unsigned CtrlW = 6;

  typedef struct packed {
    access_e     access;
    logic [1:0]  reg_offset;
    logic [7:0]  data_byte;
    logic        pin_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       ca2_level;
    logic       cb2_level;
    logic       ca2_strobed;
    logic       cb2_strobed;
    logic       irq_a;
    logic       irq_b;
  } result_t;

  typedef struct packed {
    logic [7:0]       latch_a;
    logic [7:0]       latch_b;
    logic [7:0]       dir_a;
    logic [7:0]       dir_b;
    logic [CtrlW-1:0] ctrl_a;
    logic [CtrlW-1:0] ctrl_b;
    logic             ca2_drive;
    logic             cb2_drive;
    logic             flag_a1;
    logic             flag_a2;
    logic             flag_b1;
    logic             flag_b2;
    logic [7:0]       pins_a;
    logic [7:0]       pins_b;
    logic             ca1_seen;
    logic             ca2_seen;
    logic             cb1_seen;
    logic             cb2_seen;
  } pia_state_t;

  // port A pins float high out of reset, the CA lines are seen high
  localparam pia_state_t StateReset = '{
    latch_a:   8'h00,
    latch_b:   8'h00,
    dir_a:     8'h00,
    dir_b:     8'h00,
    ctrl_a:    '0,
    ctrl_b:    '0,
    ca2_drive: 1'b0,
    cb2_drive: 1'b0,
    flag_a1:   1'b0,
    flag_a2:   1'b0,
    flag_b1:   1'b0,
    flag_b2:   1'b0,
    pins_a:    8'hFF,
    pins_b:    8'h00,
    ca1_seen:  1'b1,
    ca2_seen:  1'b1,
    cb1_seen:  1'b0,
    cb2_seen:  1'b0
  };

  // latch on output bits, pins on input bits
  function automatic logic [7:0] port_val(logic [7:0] latch, logic [7:0] dir,
                                          logic [7:0] pins);
    return (latch & dir) | (pins & ~dir);
  endfunction

  // transition toward the active level
  function automatic logic edge_hit(logic seen, logic now, logic rising);
    return (seen != now) && (now == rising);
  endfunction

  // alternate order swaps offsets 1 and 2, i.e. the two offset bits
  function automatic reg_sel_e map_offset(logic alt, logic [1:0] off);
    return alt ? reg_sel_e'({off[0], off[1]}) : reg_sel_e'(off);
  endfunction

endpackage

// ----- hdl/pia_in_if.sv -----
// input channel: one bus access or pin event per transfer
interface pia_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] access;
  logic [1:0] reg_offset;
  logic [7:0] data_byte;
  logic       pin_level;

  modport source (output valid, access, reg_offset, data_byte, pin_level, input ready);
  modport sink   (input valid, access, reg_offset, data_byte, pin_level, output ready);
endinterface

// ----- hdl/pia_out_if.sv -----
// output channel: one result per transfer
interface pia_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] port_a_pins;
  logic [7:0] port_b_pins;
  logic       ca2_level;
  logic       cb2_level;
  logic       ca2_strobed;
  logic       cb2_strobed;
  logic       irq_a;
  logic       irq_b;

  modport source (output valid, read_data, port_a_pins, port_b_pins, ca2_level, cb2_level,
                  ca2_strobed, cb2_strobed, irq_a, irq_b, input ready);
  modport sink   (input valid, read_data, port_a_pins, port_b_pins, ca2_level, cb2_level,
                  ca2_strobed, cb2_strobed, irq_a, irq_b, output ready);
endinterface

// ----- hdl/pia_in_stage.sv -----
// input register stage of the adapter
module pia_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  pia_in_if.sink            in_ch_i,
  input  logic              advance_i,
  output logic              valid_o,
  output pia_pkg::in_item_t item_o
);
  import pia_pkg::*;

  logic     valid_q;
  in_item_t item_q;
  logic     take;

  // free when empty or when the held item moves on this cycle
  assign in_ch_i.ready = !valid_q || advance_i;
  assign take          = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{access:     access_e'(in_ch_i.access),
                  reg_offset: in_ch_i.reg_offset,
                  data_byte:  in_ch_i.data_byte,
                  pin_level:  in_ch_i.pin_level};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ----- hdl/pia_core.sv -----
// adapter state registers and the per-item update and result logic
module pia_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              alt_order_i,
  input  pia_pkg::in_item_t item_i,
  output pia_pkg::result_t  result_o
);
  import pia_pkg::*;

  pia_state_t state_q, state_d;
  reg_sel_e   sel;
  logic [7:0] rd;
  logic       sa, sb;

  assign sel = map_offset(alt_order_i, item_i.reg_offset);

  always_comb begin
    state_d = state_q;
    rd      = 8'h00;
    sa      = 1'b0;
    sb      = 1'b0;
    unique case (item_i.access)
      ACC_READ: begin
        unique case (sel)
          REG_PORT_A: begin
            if (state_q.ctrl_a[CrPortSel]) begin
              rd = port_val(state_q.latch_a, state_q.dir_a, state_q.pins_a);
              state_d.flag_a1 = 1'b0;
              state_d.flag_a2 = 1'b0;
              if (state_q.ctrl_a[CrC2Out] && !state_q.ctrl_a[CrC2Bit4]) begin
                // pulse low, back high at once on e restore
                state_d.ca2_drive = state_q.ctrl_a[CrC2Bit3];
                sa = 1'b1;
              end
            end else begin
              rd = state_q.dir_a;
            end
          end
          REG_PORT_B: begin
            if (state_q.ctrl_b[CrPortSel]) begin
              rd = port_val(state_q.latch_b, state_q.dir_b, state_q.pins_b);
              if (state_q.flag_b1 && state_q.ctrl_b[CrC2Out] &&
                  !state_q.ctrl_b[CrC2Bit4] && !state_q.ctrl_b[CrC2Bit3]) begin
                state_d.cb2_drive = 1'b1;
              end
              state_d.flag_b1 = 1'b0;
              state_d.flag_b2 = 1'b0;
            end else begin
              rd = state_q.dir_b;
            end
          end
          REG_CTRL_A: begin
            rd = {state_q.flag_a1, state_q.flag_a2 && !state_q.ctrl_a[CrC2Out],
                  state_q.ctrl_a};
          end
          REG_CTRL_B: begin
            rd = {state_q.flag_b1, state_q.flag_b2 && !state_q.ctrl_b[CrC2Out],
                  state_q.ctrl_b};
          end
          default: rd = 8'h00;
        endcase
      end
      ACC_WRITE: begin
        unique case (sel)
          REG_PORT_A: begin
            if (state_q.ctrl_a[CrPortSel]) begin
              state_d.latch_a = item_i.data_byte;
            end else begin
              state_d.dir_a = item_i.data_byte;
            end
          end
          REG_PORT_B: begin
            if (state_q.ctrl_b[CrPortSel]) begin
              state_d.latch_b = item_i.data_byte;
              if (state_q.ctrl_b[CrC2Out] && !state_q.ctrl_b[CrC2Bit4]) begin
                state_d.cb2_drive = state_q.ctrl_b[CrC2Bit3];
                sb = 1'b1;
              end
            end else begin
              state_d.dir_b = item_i.data_byte;
            end
          end
          REG_CTRL_A: begin
            state_d.ctrl_a = item_i.data_byte[CtrlW-1:0];
            if (item_i.data_byte[CrC2Out]) begin
              state_d.ca2_drive = item_i.data_byte[CrC2Bit4] ?
                                  item_i.data_byte[CrC2Bit3] : 1'b1;
            end
          end
          REG_CTRL_B: begin
            state_d.ctrl_b = item_i.data_byte[CtrlW-1:0];
            if (item_i.data_byte[CrC2Out]) begin
              state_d.cb2_drive = item_i.data_byte[CrC2Bit4] ?
                                  item_i.data_byte[CrC2Bit3] : 1'b1;
            end
          end
          default: ;
        endcase
      end
      ACC_CA1: begin
        if (edge_hit(state_q.ca1_seen, item_i.pin_level, state_q.ctrl_a[CrC1Edge])) begin
          state_d.flag_a1 = 1'b1;
          // ca1 edge ends a strobe that waits for c1 restore
          if (state_q.ctrl_a[CrC2Out] && !state_q.ctrl_a[CrC2Bit4] &&
              !state_q.ctrl_a[CrC2Bit3]) begin
            state_d.ca2_drive = 1'b1;
          end
        end
        state_d.ca1_seen = item_i.pin_level;
      end
      ACC_CA2: begin
        if (!state_q.ctrl_a[CrC2Out] &&
            edge_hit(state_q.ca2_seen, item_i.pin_level, state_q.ctrl_a[CrC2Bit4])) begin
          state_d.flag_a2 = 1'b1;
        end
        state_d.ca2_seen = item_i.pin_level;
      end
      ACC_CB1: begin
        if (edge_hit(state_q.cb1_seen, item_i.pin_level, state_q.ctrl_b[CrC1Edge])) begin
          state_d.flag_b1 = 1'b1;
        end
        state_d.cb1_seen = item_i.pin_level;
      end
      ACC_CB2: begin
        if (!state_q.ctrl_b[CrC2Out] &&
            edge_hit(state_q.cb2_seen, item_i.pin_level, state_q.ctrl_b[CrC2Bit4])) begin
          state_d.flag_b2 = 1'b1;
        end
        state_d.cb2_seen = item_i.pin_level;
      end
      ACC_PINS_A: state_d.pins_a = item_i.data_byte;
      ACC_PINS_B: state_d.pins_b = item_i.data_byte;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

  // result reflects the state after this item
  always_comb begin
    result_o.read_data   = rd;
    result_o.port_a_pins = port_val(state_d.latch_a, state_d.dir_a, state_d.pins_a);
    result_o.port_b_pins = port_val(state_d.latch_b, state_d.dir_b, state_d.pins_b);
    result_o.ca2_level   = state_d.ca2_drive;
    result_o.cb2_level   = state_d.cb2_drive;
    result_o.ca2_strobed = sa;
    result_o.cb2_strobed = sb;
    result_o.irq_a       = (state_d.flag_a1 && state_d.ctrl_a[CrC1Irq]) ||
                           (state_d.flag_a2 && state_d.ctrl_a[CrC2Bit3]);
    result_o.irq_b       = (state_d.flag_b1 && state_d.ctrl_b[CrC1Irq]) ||
                           (state_d.flag_b2 && state_d.ctrl_b[CrC2Bit3]);
  end
endmodule

// ----- hdl/pia_out_stage.sv -----
// result register that drives the output channel
module pia_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pia_pkg::result_t result_i,
  output logic             free_o,
  pia_out_if.source        out_ch_o
);
  import pia_pkg::*;

  logic    valid_q;
  result_t result_q;

  // room for a new result when empty or when the held one leaves now
  assign free_o = !valid_q || out_ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_ch_o.valid       = valid_q;
  assign out_ch_o.read_data   = result_q.read_data;
  assign out_ch_o.port_a_pins = result_q.port_a_pins;
  assign out_ch_o.port_b_pins = result_q.port_b_pins;
  assign out_ch_o.ca2_level   = result_q.ca2_level;
  assign out_ch_o.cb2_level   = result_q.cb2_level;
  assign out_ch_o.ca2_strobed = result_q.ca2_strobed;
  assign out_ch_o.cb2_strobed = result_q.cb2_strobed;
  assign out_ch_o.irq_a       = result_q.irq_a;
  assign out_ch_o.irq_b       = result_q.irq_b;
endmodule

// ----- hdl/peripheral_interface_adapter_unit.sv -----
// top level of the two-port parallel interface adapter
// Two-port parallel interface adapter. Each input transfer is one bus read or
// write of one of four registers (0 port A/DDR A, 1 control A, 2 port B/DDR B,
// 3 control B; the alternate order register swaps offsets 1 and 2), a new
// level on CA1, CA2, CB1 or CB2, or a new byte on the port A or port B pins.
// Each input transfer gives exactly one output transfer with the read data
// (zero for anything but a read), both port values, both C2 levels, the C2
// strobe marks and both interrupt lines, all as they stand after the item.
// Throughput is one item per clock while the sink keeps taking results: an
// item sits in the input register, and decode and state update carry it
// into the result register, which drives the output channel. The adapter
// state (latches, direction and control registers, flags, pin and edge
// history) is updated in the cycle the item moves into the result register,
// so the next item already sees it. While a finished result waits for the
// sink the input register still takes one more item; the input stalls only
// once both registers hold an item.
// The alternate order register is written through cfg_we_i / cfg_data_i and
// is expected to change only while no item is in flight.
module peripheral_interface_adapter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  pia_in_if.sink     in_ch_i,
  pia_out_if.source  out_ch_o
);
  import pia_pkg::*;

  logic     alt_order_q;
  logic     item_valid;
  in_item_t item;
  logic     out_free;
  logic     fire;
  result_t  result;

  // alternate register ordering, written directly from the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      alt_order_q <= cfg_data_i;
    end
  end

  // an item is processed when it is held and the result register has room
  assign fire = item_valid && out_free;

  pia_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .advance_i (fire),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  pia_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .alt_order_i (alt_order_q),
    .item_i      (item),
    .result_o    (result)
  );

  pia_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result),
    .free_o   (out_free),
    .out_ch_o (out_ch_o)
  );
endmodule

// ----- tb/sv/tb_peripheral_interface_adapter_unit.sv -----
// self-checking testbench of the parallel interface adapter: directed and random traffic
module tb_peripheral_interface_adapter_unit;
  import pia_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned TailCycles  = 8;
  // a few hundred items with 45 percent stalls: far below this
  localparam int unsigned CycleLimit  = 200000;

  // control register bit positions as the adapter defines them
  localparam int unsigned C1IrqEn  = 0;
  localparam int unsigned C1Rising = 1;
  localparam int unsigned PortSel  = 2;
  localparam int unsigned C2Bit3   = 3;
  localparam int unsigned C2Bit4   = 4;
  localparam int unsigned C2Output = 5;

  localparam int unsigned SendIdlePct = 45;
  localparam int unsigned RecvIdlePct = 45;
  localparam int unsigned BothIdlePct = 16;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // shapes of the well-formed random sequences
  typedef enum logic [1:0] {
    RUN_STROBE,
    RUN_C2_INPUT,
    RUN_C2_LEVEL
  } run_kind_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  pia_in_if  in_ch ();
  pia_out_if out_ch ();

  peripheral_interface_adapter_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  // ---------------------------------------------------------------------
  // adapter state as predicted, starting from its reset values
  // ---------------------------------------------------------------------
  logic       alt_order = 1'b0;
  logic [7:0] latch_a   = 8'h00;
  logic [7:0] latch_b   = 8'h00;
  logic [7:0] ddr_a     = 8'h00;
  logic [7:0] ddr_b     = 8'h00;
  logic [5:0] cr_a      = 6'h00;
  logic [5:0] cr_b      = 6'h00;
  logic       ca2_out   = 1'b0;
  logic       cb2_out   = 1'b0;
  logic       irq_a1    = 1'b0;
  logic       irq_a2    = 1'b0;
  logic       irq_b1    = 1'b0;
  logic       irq_b2    = 1'b0;
  logic [7:0] pin_in_a  = 8'hFF;  // port A floats high
  logic [7:0] pin_in_b  = 8'h00;
  logic       ca1_last  = 1'b1;
  logic       ca2_last  = 1'b1;
  logic       cb1_last  = 1'b0;
  logic       cb2_last  = 1'b0;

  in_item_t    bus_items[$];    // items waiting for the driver
  result_t     due_results[$];  // predicted results of accepted items, oldest first
  idle_mode_e  idle_mode = IDLE_NONE;
  bit          in_taken = 1'b0;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned strobes_seen = 0;
  int unsigned irqs_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------
  always begin
    clk = 1'b1;
    #ClkHalf;
    clk = 1'b0;
    #ClkHalf;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // latch drives the output bits, pins show through on input bits
  function automatic logic [7:0] mixed(logic [7:0] latch, logic [7:0] ddr, logic [7:0] pins);
    return (latch & ddr) | (pins & ~ddr);
  endfunction

  function automatic logic active_edge(logic last, logic now, logic rising);
    return (last != now) && (rising ? now : !now);
  endfunction

  // alternate order swaps control A and port B; the swap is its own inverse
  function automatic reg_sel_e order_map(reg_sel_e r);
    if (alt_order && (r == REG_CTRL_A)) return REG_PORT_B;
    if (alt_order && (r == REG_PORT_B)) return REG_CTRL_A;
    return r;
  endfunction

  // applies one item to the predicted state and returns the result it gives
  function automatic result_t step_adapter(in_item_t it);
    result_t    r;
    reg_sel_e   sel;
    logic [5:0] cw;
    r = '0;
    sel = order_map(reg_sel_e'(it.reg_offset));
    case (it.access)
      ACC_READ: begin
        case (sel)
          REG_PORT_A: begin
            if (cr_a[PortSel]) begin
              r.read_data = mixed(latch_a, ddr_a, pin_in_a);
              irq_a1 = 1'b0;
              irq_a2 = 1'b0;
              if (cr_a[C2Output] && !cr_a[C2Bit4]) begin
                // strobe pulls CA2 low; with E restore it is back high at once
                r.ca2_strobed = 1'b1;
                ca2_out = cr_a[C2Bit3];
              end
            end else begin
              r.read_data = ddr_a;
            end
          end
          REG_PORT_B: begin
            if (cr_b[PortSel]) begin
              r.read_data = mixed(latch_b, ddr_b, pin_in_b);
              // a pending CB1 flag lets the read end a C1-restore strobe
              if (irq_b1 && cr_b[C2Output] && !cr_b[C2Bit4] && !cr_b[C2Bit3]) begin
                cb2_out = 1'b1;
              end
              irq_b1 = 1'b0;
              irq_b2 = 1'b0;
            end else begin
              r.read_data = ddr_b;
            end
          end
          REG_CTRL_A: r.read_data = {irq_a1, irq_a2 & !cr_a[C2Output], cr_a};
          default:    r.read_data = {irq_b1, irq_b2 & !cr_b[C2Output], cr_b};
        endcase
      end
      ACC_WRITE: begin
        case (sel)
          REG_PORT_A: begin
            if (cr_a[PortSel]) latch_a = it.data_byte;
            else ddr_a = it.data_byte;
          end
          REG_PORT_B: begin
            if (cr_b[PortSel]) begin
              latch_b = it.data_byte;
              if (cr_b[C2Output] && !cr_b[C2Bit4]) begin
                r.cb2_strobed = 1'b1;
                cb2_out = cr_b[C2Bit3];
              end
            end else begin
              ddr_b = it.data_byte;
            end
          end
          REG_CTRL_A: begin
            cw = it.data_byte[5:0];
            if (cw[C2Output]) ca2_out = cw[C2Bit4] ? cw[C2Bit3] : 1'b1;
            cr_a = cw;
          end
          default: begin
            cw = it.data_byte[5:0];
            if (cw[C2Output]) cb2_out = cw[C2Bit4] ? cw[C2Bit3] : 1'b1;
            cr_b = cw;
          end
        endcase
      end
      ACC_CA1: begin
        if (active_edge(ca1_last, it.pin_level, cr_a[C1Rising])) begin
          irq_a1 = 1'b1;
          if (cr_a[C2Output] && !cr_a[C2Bit4] && !cr_a[C2Bit3]) ca2_out = 1'b1;
        end
        ca1_last = it.pin_level;
      end
      ACC_CA2: begin
        if (!cr_a[C2Output] && active_edge(ca2_last, it.pin_level, cr_a[C2Bit4])) begin
          irq_a2 = 1'b1;
        end
        ca2_last = it.pin_level;
      end
      ACC_CB1: begin
        if (active_edge(cb1_last, it.pin_level, cr_b[C1Rising])) irq_b1 = 1'b1;
        cb1_last = it.pin_level;
      end
      ACC_CB2: begin
        if (!cr_b[C2Output] && active_edge(cb2_last, it.pin_level, cr_b[C2Bit4])) begin
          irq_b2 = 1'b1;
        end
        cb2_last = it.pin_level;
      end
      ACC_PINS_A: pin_in_a = it.data_byte;
      default:    pin_in_b = it.data_byte;
    endcase
    r.port_a_pins = mixed(latch_a, ddr_a, pin_in_a);
    r.port_b_pins = mixed(latch_b, ddr_b, pin_in_b);
    r.ca2_level   = ca2_out;
    r.cb2_level   = cb2_out;
    r.irq_a       = (irq_a1 & cr_a[C1IrqEn]) | (irq_a2 & cr_a[C2Bit3]);
    r.irq_b       = (irq_b1 & cr_b[C1IrqEn]) | (irq_b2 & cr_b[C2Bit3]);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // chance of an idle cycle on the sending or the receiving side
  function automatic int unsigned idle_pct(logic recv_side);
    case (idle_mode)
      IDLE_SEND: return recv_side ? 0 : SendIdlePct;
      IDLE_RECV: return recv_side ? RecvIdlePct : 0;
      IDLE_BOTH: return BothIdlePct;
      default:   return 0;
    endcase
  endfunction

  task automatic push_item(access_e a, logic [1:0] off, logic [7:0] d, logic l);
    in_item_t it;
    it.access     = a;
    it.reg_offset = off;
    it.data_byte  = d;
    it.pin_level  = l;
    bus_items.insert(bus_items.size(), it);
    items_queued++;
  endtask

  // register access by logical register; unused fields get random values
  task automatic push_bus(access_e a, reg_sel_e r, logic [7:0] d);
    push_item(a, order_map(r), d, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_line(access_e a, logic l);
    push_item(a, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), l);
  endtask

  task automatic push_pins(access_e a, logic [7:0] d);
    push_item(a, 2'($urandom_range(0, 3)), d, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_random_item();
    int unsigned pick;
    access_e     a;
    pick = $urandom_range(0, 99);
    if (pick < 30) a = ACC_READ;
    else if (pick < 60) a = ACC_WRITE;
    else if (pick < 90) a = access_e'(ACC_CA1 + $urandom_range(0, 3));
    else a = $urandom_range(0, 1) ? ACC_PINS_A : ACC_PINS_B;
    push_item(a, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  // a short well-formed sequence on one side: set the mode, move data,
  // wiggle a control line, then look at the flags and read the port
  task automatic push_sequence();
    run_kind_e  kind;
    logic       side_b;
    logic [7:0] cw;
    reg_sel_e   ctl;
    reg_sel_e   prt;
    access_e    line;
    kind   = run_kind_e'($urandom_range(0, 2));
    side_b = 1'($urandom_range(0, 1));
    cw     = 8'($urandom_range(0, 255));
    ctl    = side_b ? REG_CTRL_B : REG_CTRL_A;
    prt    = side_b ? REG_PORT_B : REG_PORT_A;
    case (kind)
      RUN_STROBE: begin
        cw[C2Output] = 1'b1;
        cw[C2Bit4]   = 1'b0;
        line = side_b ? ACC_CB1 : ACC_CA1;
      end
      RUN_C2_INPUT: begin
        cw[C2Output] = 1'b0;
        line = side_b ? ACC_CB2 : ACC_CA2;
      end
      default: begin
        cw[C2Output] = 1'b1;
        cw[C2Bit4]   = 1'b1;
        line = side_b ? ACC_CB1 : ACC_CA1;
      end
    endcase
    // now and then reach the direction register first
    if ($urandom_range(0, 3) == 0) begin
      push_bus(ACC_WRITE, ctl, cw & ~(8'h01 << PortSel));
      push_bus(ACC_WRITE, prt, 8'($urandom_range(0, 255)));
    end
    cw[PortSel] = 1'b1;
    push_bus(ACC_WRITE, ctl, cw);
    if ($urandom_range(0, 1)) push_bus(ACC_WRITE, prt, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) push_bus(ACC_READ, prt, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 3)) push_line(line, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) begin
      push_pins(side_b ? ACC_PINS_B : ACC_PINS_A, 8'($urandom_range(0, 255)));
    end
    push_bus(ACC_READ, ctl, 8'($urandom_range(0, 255)));
    push_bus(ACC_READ, prt, 8'($urandom_range(0, 255)));
  endtask

  // register write; only called while nothing is in flight
  task automatic write_alt_order(logic v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_data  = v;
    alt_order = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // every queued item accepted and every result back
  task automatic wait_drained();
    do @(negedge clk);
    while ((items_taken != items_queued) || (due_results.size() != 0));
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %02h expected %02h",
                                results_checked, name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: offers queued items on the falling edge, holds until transfer
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : feed
    in_item_t head;
    if (rst_n) begin
      out_ch.ready <= !roll(idle_pct(1'b1));
      if (!in_ch.valid || in_taken) begin
        if ((bus_items.size() != 0) && !roll(idle_pct(1'b0))) begin
          head = bus_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.access     <= head.access;
          in_ch.reg_offset <= head.reg_offset;
          in_ch.data_byte  <= head.data_byte;
          in_ch.pin_level  <= head.pin_level;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predicts on each input transfer, checks each output transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    in_item_t it;
    result_t  got;
    result_t  want;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      it = '{access:     access_e'(in_ch.access),
             reg_offset: in_ch.reg_offset,
             data_byte:  in_ch.data_byte,
             pin_level:  in_ch.pin_level};
      due_results.insert(due_results.size(), step_adapter(it));
      items_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.read_data, out_ch.port_a_pins, out_ch.port_b_pins,
              out_ch.ca2_level, out_ch.cb2_level, out_ch.ca2_strobed,
              out_ch.cb2_strobed, out_ch.irq_a, out_ch.irq_b};
      if (due_results.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
      end else begin
        want = due_results.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("port_a_pins", got.port_a_pins, want.port_a_pins);
        check_field("port_b_pins", got.port_b_pins, want.port_b_pins);
        check_field("ca2_level", 8'(got.ca2_level), 8'(want.ca2_level));
        check_field("cb2_level", 8'(got.cb2_level), 8'(want.cb2_level));
        check_field("ca2_strobed", 8'(got.ca2_strobed), 8'(want.ca2_strobed));
        check_field("cb2_strobed", 8'(got.cb2_strobed), 8'(want.cb2_strobed));
        check_field("irq_a", 8'(got.irq_a), 8'(want.irq_a));
        check_field("irq_b", 8'(got.irq_b), 8'(want.irq_b));
        if (want.ca2_strobed || want.cb2_strobed) strobes_seen++;
        if (want.irq_a || want.irq_b) irqs_seen++;
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d items taken, %0d results due",
               cycles, items_taken, items_queued, due_results.size());
      $display("FAIL peripheral_interface_adapter_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer: reset, directed checks, then random phases
  // ---------------------------------------------------------------------
  initial begin
    int unsigned goal;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.access     = ACC_READ;
    in_ch.reg_offset = '0;
    in_ch.data_byte  = '0;
    in_ch.pin_level  = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_alt_order(1'b0);

    // port A: reset view, direction register, strobe with CA1 restore
    push_bus(ACC_READ, REG_CTRL_A, 8'h00);
    push_bus(ACC_WRITE, REG_PORT_A, 8'hF0);     // selects DDR A out of reset
    push_bus(ACC_READ, REG_PORT_A, 8'h00);
    push_bus(ACC_WRITE, REG_CTRL_A, 8'hE7);     // top two bits must be dropped
    push_bus(ACC_WRITE, REG_PORT_A, 8'hFF);
    push_pins(ACC_PINS_A, 8'h00);
    push_bus(ACC_READ, REG_PORT_A, 8'h00);      // strobe, CA2 stays low
    push_line(ACC_CA1, 1'b0);                   // wrong direction, no flag
    push_line(ACC_CA1, 1'b1);                   // flag, irq, releases CA2
    push_bus(ACC_READ, REG_CTRL_A, 8'h00);
    push_bus(ACC_READ, REG_PORT_A, 8'h00);      // clears both A flags
    // E restore: pulse is marked though the line ends high
    push_bus(ACC_WRITE, REG_CTRL_A, 8'h2C);
    push_bus(ACC_READ, REG_PORT_A, 8'h00);
    // CA2 as input, then turned to a set/reset output with its flag still up
    push_bus(ACC_WRITE, REG_CTRL_A, 8'h1C);
    push_line(ACC_CA2, 1'b0);
    push_line(ACC_CA2, 1'b1);
    push_bus(ACC_WRITE, REG_CTRL_A, 8'h3C);
    push_bus(ACC_READ, REG_CTRL_A, 8'h00);      // flag 2 hidden while an output
    push_bus(ACC_WRITE, REG_CTRL_A, 8'h30);
    // port B: write strobe, CB1 does not release, the read does
    push_bus(ACC_WRITE, REG_PORT_B, 8'h0F);
    push_bus(ACC_WRITE, REG_CTRL_B, 8'h25);
    push_bus(ACC_WRITE, REG_PORT_B, 8'hFF);
    push_line(ACC_CB1, 1'b1);
    push_line(ACC_CB1, 1'b0);
    push_pins(ACC_PINS_B, 8'hFF);
    push_bus(ACC_READ, REG_PORT_B, 8'h00);
    push_bus(ACC_WRITE, REG_CTRL_B, 8'h1C);
    push_line(ACC_CB2, 1'b1);
    push_bus(ACC_READ, REG_CTRL_B, 8'h00);
    wait_drained();

    // every idle mode once with each register order
    for (int p = 0; p < PhaseCount; p++) begin
      write_alt_order(p[0] ^ p[2]);
      idle_mode = idle_mode_e'(p % 4);
      goal = items_queued + RandomItems / PhaseCount;
      while (items_queued < goal) begin
        if ($urandom_range(0, 9) < 6) push_sequence();
        else push_random_item();
      end
      wait_drained();
    end

    // catch any stray result after the last expected one
    repeat (TailCycles) @(negedge clk);

    $display("checked %0d results over %0d random phases, both register orders, all idle modes",
             results_checked, PhaseCount);
    $display("%0d results carried a C2 strobe, %0d an interrupt; %0d mismatches",
             strobes_seen, irqs_seen, errors);
    if (errors == 0) begin
      $display("PASS peripheral_interface_adapter_unit");
    end else begin
      $display("FAIL peripheral_interface_adapter_unit");
    end
    $finish;
  end

endmodule
